// File: design/nnis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int PIX_W      = 32;
    localparam int SRC_CFG_W  = 9;
    localparam int TGT_CFG_W  = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT = 3'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    typedef struct packed {
        logic cfg_wr;
        logic div_load;
        logic div_step;
        logic step_load;
        logic load_wr;
        logic emit_start;
        logic addr_en;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic cfg_hit;
    } t_dp_status;

endpackage

// File: design/nnis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/nnis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_ctrl
// Controller: step-ratio division sequence, load and emit item sequencing.
// ----------------------------------------------------------------------------
module nnis_ctrl #(
    parameter int DIV_STEPS = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_acc,
    input  logic                 i_cfg_acc,
    input  logic                 i_cfg_valid,
    input  logic                 i_mode,
    input  nnis_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output logic                 o_cfg_ready,
    output nnis_pkg::t_dp_cmd    o_cmd
);
    import nnis_pkg::*;

    localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [2:0] S_DSTART = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_DEND   = 3'd2;
    localparam logic [2:0] S_IDLE   = 3'd3;
    localparam logic [2:0] S_ADR    = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DSTART;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_DSTART: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DEND;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DEND: begin
                o_cmd.step_load = 1'b1;
                n_state         = S_IDLE;
            end
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_acc) begin
                    o_cmd.cfg_wr = 1'b1;
                    if (i_status.cfg_hit) begin
                        n_state = S_DSTART;
                    end
                end else if (i_in_acc) begin
                    if (i_mode == MODE_EMIT) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_ADR;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_ADR: begin
                o_cmd.addr_en = 1'b1;
                n_state       = S_RD;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_DSTART;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_dual_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_acc && i_cfg_acc))
        else $error("item and register write accepted together");

    a_cfg_blocks_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_acc && i_status.cfg_hit) |=> !o_in_ready && !o_cfg_ready)
        else $error("ports open while step ratios are recomputed");
`endif

endmodule

// File: design/nnis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_datapath
// Datapath: size registers, step dividers, positions, address math,
// source store and output register.
// ----------------------------------------------------------------------------
module nnis_datapath #(
    parameter int MAX_SOURCE_DIM = 256,
    parameter int MAX_TARGET_DIM = 2048,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nnis_pkg::t_dp_cmd                   i_cmd,
    output nnis_pkg::t_dp_status                o_status,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [nnis_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [nnis_pkg::PIX_W-1:0]          o_pixel,
    output logic                                o_last
);
    import nnis_pkg::*;

    localparam int SD_W    = $clog2(MAX_SOURCE_DIM + 1);
    localparam int SIDX_W  = $clog2(MAX_SOURCE_DIM);
    localparam int TD_W    = $clog2(MAX_TARGET_DIM + 1);
    localparam int TPOS_W  = $clog2(MAX_TARGET_DIM);
    localparam int NUM_W   = SD_W + FRACTION_BITS;
    localparam int PROD_W  = TPOS_W + NUM_W;
    localparam int SH_W    = PROD_W - FRACTION_BITS;
    localparam int DEPTH   = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TOT_W   = $clog2(DEPTH + 1);
    localparam int MADD_W  = SIDX_W + SD_W + 1;

    function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SD_W-1:0]   r_sw, r_sh;
    logic [TD_W-1:0]   r_tw, r_th;
    logic [TOT_W-1:0]  r_total;
    logic [NUM_W-1:0]  r_num_x, r_num_y;
    logic [TD_W-1:0]   r_rem_x, r_rem_y;
    logic [NUM_W-1:0]  r_step_x, r_step_y;
    logic [ADDR_W-1:0] r_load_pos;
    logic [TPOS_W-1:0] r_col, r_row;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic              r_last;
    logic [ADDR_W-1:0] r_addr;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_last;

    logic [31:0]       w_src_eff, w_tgt_eff;
    logic              w_cfg_hit;
    logic [TD_W:0]     w_trial_x, w_trial_y;
    logic              w_ge_x, w_ge_y;
    logic [TOT_W-1:0]  w_pos_inc;
    logic [TD_W-1:0]   w_col_inc, w_row_inc;
    logic              w_col_end, w_row_end;
    logic [SH_W-1:0]   w_shx, w_shy, w_limx, w_limy;
    logic [SIDX_W-1:0] w_sx, w_sy;
    logic [MADD_W-1:0] w_addr;
    logic [PIX_W-1:0]  w_rdata;

    assign w_src_eff = clamp_dim(32'(i_cfg_data[SRC_CFG_W-1:0]), 32'(MAX_SOURCE_DIM));
    assign w_tgt_eff = clamp_dim(32'(i_cfg_data[TGT_CFG_W-1:0]), 32'(MAX_TARGET_DIM));
    assign w_cfg_hit = (i_cfg_index <= CFG_TGT_HEIGHT);

    // restoring dividers, one quotient bit per cycle
    assign w_trial_x = {r_rem_x, r_num_x[NUM_W-1]};
    assign w_trial_y = {r_rem_y, r_num_y[NUM_W-1]};
    assign w_ge_x    = w_trial_x >= {1'b0, r_tw};
    assign w_ge_y    = w_trial_y >= {1'b0, r_th};

    assign w_pos_inc = TOT_W'(r_load_pos) + TOT_W'(1);
    assign w_col_inc = TD_W'(r_col) + TD_W'(1);
    assign w_row_inc = TD_W'(r_row) + TD_W'(1);
    assign w_col_end = (w_col_inc == r_tw);
    assign w_row_end = (w_row_inc == r_th);

    assign w_shx  = r_prod_x[PROD_W-1:FRACTION_BITS];
    assign w_shy  = r_prod_y[PROD_W-1:FRACTION_BITS];
    assign w_limx = SH_W'(r_sw - SD_W'(1));
    assign w_limy = SH_W'(r_sh - SD_W'(1));
    assign w_sx   = (w_shx > w_limx) ? w_limx[SIDX_W-1:0] : w_shx[SIDX_W-1:0];
    assign w_sy   = (w_shy > w_limy) ? w_limy[SIDX_W-1:0] : w_shy[SIDX_W-1:0];
    assign w_addr = MADD_W'(w_sy) * MADD_W'(r_sw) + MADD_W'(w_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw       <= SD_W'(1);
            r_sh       <= SD_W'(1);
            r_tw       <= TD_W'(1);
            r_th       <= TD_W'(1);
            r_total    <= TOT_W'(1);
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_sw <= SD_W'(w_src_eff);
                    CFG_SRC_HEIGHT: r_sh <= SD_W'(w_src_eff);
                    CFG_TGT_WIDTH:  r_tw <= TD_W'(w_tgt_eff);
                    CFG_TGT_HEIGHT: r_th <= TD_W'(w_tgt_eff);
                    default: ;
                endcase
                if (w_cfg_hit) begin
                    r_load_pos <= '0;
                    r_col      <= '0;
                    r_row      <= '0;
                end
            end
            if (i_cmd.div_load) begin
                r_total <= TOT_W'(r_sw) * TOT_W'(r_sh);
            end
            if (i_cmd.load_wr) begin
                r_load_pos <= (w_pos_inc == r_total) ? '0 : w_pos_inc[ADDR_W-1:0];
            end
            if (i_cmd.emit_start) begin
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : w_row_inc[TPOS_W-1:0];
                end else begin
                    r_col <= w_col_inc[TPOS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num_x <= {r_sw, {FRACTION_BITS{1'b0}}};
            r_num_y <= {r_sh, {FRACTION_BITS{1'b0}}};
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_x <= w_ge_x ? TD_W'(w_trial_x - {1'b0, r_tw}) : w_trial_x[TD_W-1:0];
            r_rem_y <= w_ge_y ? TD_W'(w_trial_y - {1'b0, r_th}) : w_trial_y[TD_W-1:0];
            r_num_x <= {r_num_x[NUM_W-2:0], w_ge_x};
            r_num_y <= {r_num_y[NUM_W-2:0], w_ge_y};
        end
        if (i_cmd.step_load) begin
            r_step_x <= r_num_x + NUM_W'(1);
            r_step_y <= r_num_y + NUM_W'(1);
        end
        if (i_cmd.emit_start) begin
            r_prod_x <= PROD_W'(r_col) * PROD_W'(r_step_x);
            r_prod_y <= PROD_W'(r_row) * PROD_W'(r_step_y);
            r_last   <= w_col_end && w_row_end;
        end
        if (i_cmd.addr_en) begin
            r_addr <= w_addr[ADDR_W-1:0];
        end
    end

    nnis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (r_load_pos),
        .i_wdata (i_pixel),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pix  <= w_rdata;
            r_out_last <= r_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.cfg_hit  = w_cfg_hit;
    assign o_out_valid       = r_out_valid;
    assign o_pixel           = r_out_pix;
    assign o_last            = r_out_last;

`ifndef ASSERT_OFF
    a_load_pos_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TOT_W'(r_load_pos) < r_total)
        else $error("load position beyond source image");

    a_out_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TD_W'(r_col) < r_tw) && (TD_W'(r_row) < r_th))
        else $error("output position beyond target frame");

    a_addr_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.addr_en) |-> (TOT_W'(r_addr) < r_total))
        else $error("source address beyond source image");
`endif

endmodule

// File: design/nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor scaler with 9.16 fixed-point step ratios (at defaults).
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tuser selects load (0) or emit (1). A load
// writes tdata into the source store at the next raster position and gives
// no result. An emit produces the next destination pixel on m_axis, with
// tlast on the final pixel of the frame.
// Registers (cfg port, index 0..3): source width, source height, target
// width, target height; other indexes are ignored. Each size write restarts
// load and emit positions and recomputes both step ratios with two bit-serial
// dividers in parallel (states DSTART, DIV, DEND), during which neither port
// is ready. The same sequence runs after reset.
// A load leaves the block ready for the next item. An emit runs through its
// steps in order (multiply, address multiply-add, store read, output load);
// no item is taken before its output load, which raises m_axis_tvalid.
// The output register holds a result while m_axis_tready is low; loads are
// still taken, and a following emit waits in its last step until the
// register frees up.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
    parameter int MAX_SOURCE_DIM = 256,
    parameter int MAX_TARGET_DIM = 2048,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nnis_pkg::PIX_W-1:0]      s_axis_tdata,   // [31:0] pixel_in
    input  logic                            s_axis_tuser,   // [0] mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nnis_pkg::PIX_W-1:0]      m_axis_tdata,   // [31:0] pixel_out
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nnis_pkg::*;

    localparam int DIV_STEPS = $clog2(MAX_SOURCE_DIM + 1) + FRACTION_BITS;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_acc;
    logic       w_cfg_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;

    nnis_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (w_in_acc),
        .i_cfg_acc   (w_cfg_acc),
        .i_cfg_valid (i_cfg_valid),
        .i_mode      (s_axis_tuser),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    nnis_datapath #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .MAX_TARGET_DIM (MAX_TARGET_DIM),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_pixel     (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
